// ===== hdl/uqae_pkg.sv =====
// ----------------------------------------------------------------------------
// uqae_pkg
// Shared types, character codes and helpers for the URL query argument
// extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package uqae_pkg;

    localparam int MAX_KEY_BYTES = 8;
    localparam int COUNT_WIDTH   = 16;
    localparam int KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_W         = 8 * MAX_KEY_BYTES;
    localparam int KLEN_W        = 4;
    localparam int CAP_W         = 11;
    localparam int LEN_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int NUM_SLOTS     = 3;

    localparam logic [KLEN_W-1:0]      KEY_MAX   = KLEN_W'(MAX_KEY_BYTES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_TO_QUERY  = 2'd3;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 11'd16;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [6:0] {
        PH_DONE    = 7'b0000001,
        PH_SKIP    = 7'b0000010,
        PH_MATCH   = 7'b0000100,
        PH_SKIPSEG = 7'b0001000,
        PH_VALUE   = 7'b0010000,
        PH_PCT1    = 7'b0100000,
        PH_PCT2    = 7'b1000000
    } t_phase;

    typedef struct packed {
        t_phase                 phase;
        logic [KLEN_W-1:0]      match_index;
        logic [7:0]             held_hex_char;
        logic [CAP_W-1:0]       room_left;
        logic [COUNT_WIDTH-1:0] char_count;
    } t_state;

    typedef struct packed {
        logic [7:0]       value_byte;
        logic             end_flag;
        logic             found;
        logic [LEN_W-1:0] decoded_length;
    } t_result;

    typedef struct packed {
        t_result [NUM_SLOTS-1:0] res;
        logic [1:0]              cnt;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] d;
        u = (c >= 8'h61) ? c - 8'h20 : c;
        d = (u >= 8'h41) ? u - 8'h37 : u - 8'h30;
        return d[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/uqae_step.sv =====
// ----------------------------------------------------------------------------
// uqae_step
// Per-byte parser step: name match, percent decoding, room and count update,
// and the list of up to three results caused by one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module uqae_step (
    input  var uqae_pkg::t_state                   i_state,
    input  wire logic [uqae_pkg::KEY_W-1:0]        i_key_bytes,
    input  wire logic [uqae_pkg::KLEN_W-1:0]       i_key_length,
    input  wire logic [uqae_pkg::CAP_W-1:0]        i_capacity,
    input  wire logic                              i_skip_to_query,
    input  wire logic [7:0]                        i_char,
    input  wire logic                              i_first,
    output uqae_pkg::t_state                       o_state,
    output uqae_pkg::t_bundle                      o_bundle
);
    import uqae_pkg::*;

    t_state                     st;
    t_state                     nxt;
    logic [7:0]                 chars [NUM_SLOTS];
    logic [1:0]                 n_chars;
    logic                       fin;
    logic                       fnd;
    logic                       clr_count;
    logic                       do_vc;
    logic                       fall;
    logic [KLEN_W-1:0]          klen;
    logic [7:0]                 kbyte;
    logic [CAP_W-1:0]           avail;
    logic [1:0]                 k;
    logic [COUNT_WIDTH+1:0]     sum;
    logic [COUNT_WIDTH-1:0]     cnt_new;
    logic [47:0]                cnt_ext;
    logic                       c_term;
    logic                       c_hex;

    always_comb begin
        st = i_state;
        if (i_first) begin
            st.char_count    = '0;
            st.held_hex_char = '0;
            st.match_index   = '0;
            st.room_left     = i_capacity;
            st.phase         = i_skip_to_query ? PH_SKIP : PH_MATCH;
        end

        nxt       = st;
        chars[0]  = '0;
        chars[1]  = '0;
        chars[2]  = '0;
        n_chars   = '0;
        fin       = 1'b0;
        fnd       = 1'b0;
        clr_count = 1'b0;
        do_vc     = 1'b0;
        fall      = 1'b0;
        c_term    = (i_char == CH_NUL) || (i_char == CH_AMP) || (i_char == CH_SPACE);
        c_hex     = is_hex(i_char);
        klen      = (i_key_length > KEY_MAX) ? KEY_MAX : i_key_length;
        kbyte     = i_key_bytes[8*st.match_index[KEY_IDX_W-1:0] +: 8];

        case (st.phase)
            PH_SKIP: begin
                if (i_char == CH_QUEST) begin
                    nxt.phase       = PH_MATCH;
                    nxt.match_index = '0;
                end else if (i_char == CH_NUL) begin
                    fin = 1'b1;
                end
            end
            PH_MATCH: begin
                if (st.match_index == '0 && i_char == CH_NUL) begin
                    fin = 1'b1;
                end else begin
                    fall = 1'b1;
                    if (st.match_index >= klen) begin
                        if (i_char == CH_NUL) begin
                            fin       = 1'b1;
                            fnd       = 1'b1;
                            clr_count = 1'b1;
                            fall      = 1'b0;
                        end else if (i_char == CH_EQUAL) begin
                            nxt.phase = PH_VALUE;
                            fall      = 1'b0;
                        end
                    end else if (i_char != CH_NUL && i_char != CH_AMP && i_char == kbyte) begin
                        nxt.match_index = st.match_index + 1'b1;
                        fall            = 1'b0;
                    end
                    if (fall) begin
                        if (i_char == CH_NUL) begin
                            fin = 1'b1;
                        end else if (i_char == CH_AMP) begin
                            nxt.match_index = '0;
                        end else begin
                            nxt.phase = PH_SKIPSEG;
                        end
                    end
                end
            end
            PH_SKIPSEG: begin
                if (i_char == CH_AMP) begin
                    nxt.phase       = PH_MATCH;
                    nxt.match_index = '0;
                end else if (i_char == CH_NUL) begin
                    fin = 1'b1;
                end
            end
            PH_VALUE: begin
                do_vc = 1'b1;
            end
            PH_PCT1: begin
                if (c_hex) begin
                    nxt.held_hex_char = i_char;
                    nxt.phase         = PH_PCT2;
                end else begin
                    chars[0] = CH_PERCENT;
                    n_chars  = 2'd1;
                    do_vc    = 1'b1;
                end
            end
            PH_PCT2: begin
                nxt.phase = PH_VALUE;
                if (c_hex) begin
                    chars[0] = {hex_val(st.held_hex_char), hex_val(i_char)};
                    n_chars  = 2'd1;
                end else begin
                    chars[0] = CH_PERCENT;
                    chars[1] = st.held_hex_char;
                    n_chars  = 2'd2;
                    do_vc    = 1'b1;
                end
            end
            default: begin
                nxt.phase = PH_DONE;
            end
        endcase

        // value character after any pending escape bytes
        if (do_vc) begin
            if (c_term) begin
                fin = 1'b1;
                fnd = 1'b1;
            end else if (i_char == CH_PERCENT) begin
                nxt.phase = PH_PCT1;
            end else begin
                chars[n_chars] = (i_char == CH_PLUS) ? CH_SPACE : i_char;
                n_chars        = n_chars + 2'd1;
                nxt.phase      = PH_VALUE;
            end
        end

        if (fin) begin
            nxt.phase = PH_DONE;
        end

        avail = (st.room_left > CAP_W'(1)) ? st.room_left - CAP_W'(1) : '0;
        k     = (avail < CAP_W'(n_chars)) ? avail[1:0] : n_chars;
        nxt.room_left = st.room_left - CAP_W'(k);

        sum = {2'b00, st.char_count} + (COUNT_WIDTH+2)'(n_chars);
        if (clr_count) begin
            cnt_new = '0;
        end else if (sum > {2'b00, COUNT_MAX}) begin
            cnt_new = COUNT_MAX;
        end else begin
            cnt_new = sum[COUNT_WIDTH-1:0];
        end
        nxt.char_count = cnt_new;
        cnt_ext        = {{(48-COUNT_WIDTH){1'b0}}, cnt_new};

        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_bundle.res[i] = '0;
            if (2'(i) < k) begin
                o_bundle.res[i].value_byte = chars[i];
            end else if (2'(i) == k) begin
                o_bundle.res[i].end_flag       = 1'b1;
                o_bundle.res[i].found          = fnd;
                o_bundle.res[i].decoded_length = fnd ? cnt_ext[LEN_W-1:0] : '0;
            end
        end
        o_bundle.cnt = k + {1'b0, fin};
        o_state      = nxt;
    end

endmodule

`default_nettype wire

// ===== hdl/uqae_out.sv =====
// ----------------------------------------------------------------------------
// uqae_out
// Result register holding up to three results of one byte, handed out one
// item per cycle on the master side while the master is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module uqae_out (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  var uqae_pkg::t_bundle i_bundle,
    input  wire logic           i_m_ready,
    output logic                o_m_valid,
    output uqae_pkg::t_result   o_result,
    output logic                o_in_ready
);
    import uqae_pkg::*;

    t_result    r_slot [NUM_SLOTS];
    t_result    n_slot [NUM_SLOTS];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_m_ready;
    assign o_m_valid  = (r_cnt != 2'd0);
    assign o_result   = r_slot[0];
    assign o_in_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_m_ready);

    always_comb begin
        n_slot = r_slot;
        n_cnt  = r_cnt;
        if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
            n_cnt     = r_cnt - 2'd1;
        end
        if (i_push) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                n_slot[i] = i_bundle.res[i];
            end
            n_cnt = i_bundle.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt >= 2'd2) |-> !o_in_ready)
        else $error("input accepted while results still queued");

    a_push_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== hdl/url_query_argument_extractor_core.sv =====
// ----------------------------------------------------------------------------
// url_query_argument_extractor_core
// Finds a named argument in a URL byte stream and percent-decodes its value.
// Latency: first result of a byte appears on the cycle after it is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the
// master is ready; a byte giving more results holds the next until its last is taken.
// Reset (synchronous, active low) clears parser state and empties the output;
// registers return to: empty name, capacity 16, skip to query on.
// ----------------------------------------------------------------------------
`default_nettype none

module url_query_argument_extractor_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,   // text_byte
    input  wire logic                            s_axis_tuser,   // first
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [23:0]                          m_axis_tdata,   // value_byte, decoded_length
    output logic                                 m_axis_tlast,   // end_flag
    output logic                                 m_axis_tuser,   // found
    input  wire logic                            i_cfg_we,
    input  wire logic [uqae_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [uqae_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import uqae_pkg::*;

    logic [KEY_W-1:0]  r_key_bytes;
    logic [KLEN_W-1:0] r_key_length;
    logic [CAP_W-1:0]  r_capacity;
    logic              r_skip_to_query;
    t_state            r_state;
    t_state            n_state;
    t_bundle           step_bundle;
    t_result           out_res;
    logic              accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes     <= '0;
            r_key_length    <= '0;
            r_capacity      <= CAPACITY_RESET;
            r_skip_to_query <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_BYTES:      r_key_bytes     <= i_cfg_data[KEY_W-1:0];
                CFG_KEY_LENGTH:     r_key_length    <= i_cfg_data[KLEN_W-1:0];
                CFG_VALUE_CAPACITY: r_capacity      <= i_cfg_data[CAP_W-1:0];
                CFG_SKIP_TO_QUERY:  r_skip_to_query <= i_cfg_data[0];
                default:            r_skip_to_query <= r_skip_to_query;
            endcase
        end
    end

    uqae_step u_step (
        .i_state         (r_state),
        .i_key_bytes     (r_key_bytes),
        .i_key_length    (r_key_length),
        .i_capacity      (r_capacity),
        .i_skip_to_query (r_skip_to_query),
        .i_char          (s_axis_tdata),
        .i_first         (s_axis_tuser),
        .o_state         (n_state),
        .o_bundle        (step_bundle)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_DONE;
            r_state.match_index   <= '0;
            r_state.held_hex_char <= '0;
            r_state.room_left     <= '0;
            r_state.char_count    <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    uqae_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_bundle   (step_bundle),
        .i_m_ready  (m_axis_tready),
        .o_m_valid  (m_axis_tvalid),
        .o_result   (out_res),
        .o_in_ready (s_axis_tready)
    );

    assign m_axis_tdata = {out_res.decoded_length, out_res.value_byte};
    assign m_axis_tlast = out_res.end_flag;
    assign m_axis_tuser = out_res.found;

    a_end_goes_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && step_bundle.cnt != 2'd0 &&
         step_bundle.res[step_bundle.cnt - 2'd1].end_flag) |=> (r_state.phase == PH_DONE))
        else $error("end result without return to done");

    a_match_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.match_index <= KEY_MAX)
        else $error("match index beyond name length");

    a_room_nonincreasing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser) |=> (r_state.room_left <= $past(r_state.room_left)))
        else $error("room grew within a string");

endmodule

`default_nettype wire
